### design/request_spacing_backoff_retry_defines.svh
// Assertion macros shared by the checker of request_spacing_backoff_retry.
`ifndef REQUEST_SPACING_BACKOFF_RETRY_DEFINES_SVH
`define REQUEST_SPACING_BACKOFF_RETRY_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define RSD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define RSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that stays live through reset.
`define RSD_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

### design/rsd_pkg.sv
// Shared types and constants of the request spacing and backoff gate.
`default_nettype none

package rsd_pkg;

   localparam int CMD_W     = 2;
   localparam int CODE_W    = 8;
   localparam int STATUS_W  = 10;
   localparam int EVENT_W   = 2;
   localparam int COUNT_W   = 4;
   localparam int MS_W      = 16;
   localparam int WAIT_W    = 30;  // base backoff shifted by up to 14
   localparam int PHASE_W   = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Commands
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESULT  = 2'd2;

   // Result events
   localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
   localparam logic [EVENT_W-1:0] EV_START = 2'd1;
   localparam logic [EVENT_W-1:0] EV_DONE  = 2'd2;
   localparam logic [EVENT_W-1:0] EV_BUSY  = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_SPACING      = 2'd0;
   localparam logic [1:0] REG_RETRY_LIMIT  = 2'd1;
   localparam logic [1:0] REG_BACKOFF_BASE = 2'd2;

   localparam logic [MS_W-1:0]    SPACING_RST      = 16'd400;
   localparam logic [COUNT_W-1:0] RETRY_LIMIT_RST  = 4'd6;
   localparam logic [MS_W-1:0]    BACKOFF_BASE_RST = 16'd1000;

   localparam logic [STATUS_W-1:0] RATE_LIMITED_STATUS = 10'd429;
   localparam logic [MS_W-1:0]     SINCE_SATURATED     = 16'hFFFF;

   typedef struct packed {
      logic [MS_W-1:0]    spacing_ms;
      logic [COUNT_W-1:0] retry_limit;
      logic [MS_W-1:0]    backoff_base_ms;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]           command;
      logic signed [CODE_W-1:0]   attempt_code;
      logic [STATUS_W-1:0]        http_status;
   } req_type;

   typedef struct packed {
      logic [EVENT_W-1:0]         event_res;
      logic signed [CODE_W-1:0]   final_code;
      logic [STATUS_W-1:0]        final_status;
      logic [COUNT_W-1:0]         attempt_index;
   } rsp_type;

endpackage

`default_nettype wire

### design/rsd_if.sv
// Request and result channel interfaces of the request spacing gate.
`default_nettype none

interface rsd_req_if;
   logic                               valid;
   logic                               ready;
   logic [rsd_pkg::CMD_W-1:0]          command;
   logic signed [rsd_pkg::CODE_W-1:0]  attempt_code;
   logic [rsd_pkg::STATUS_W-1:0]       http_status;

   modport source (output valid, command, attempt_code, http_status, input ready);
   modport sink   (input valid, command, attempt_code, http_status, output ready);
endinterface

interface rsd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rsd_pkg::EVENT_W-1:0]        event_res;
   logic signed [rsd_pkg::CODE_W-1:0]  final_code;
   logic [rsd_pkg::STATUS_W-1:0]       final_status;
   logic [rsd_pkg::COUNT_W-1:0]        attempt_index;

   modport source (output valid, event_res, final_code, final_status, attempt_index,
                   input ready);
   modport sink   (input valid, event_res, final_code, final_status, attempt_index,
                   output ready);
endinterface

`default_nettype wire

### design/rsd_csr.sv
// Configuration registers behind the APB-style write/read port.
`default_nettype none

module rsd_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [rsd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [rsd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [rsd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output rsd_pkg::cfg_type                      cfg
);

   rsd_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rsd_pkg::REG_SPACING:      cfg_in.spacing_ms = pwdata[rsd_pkg::MS_W-1:0];
            rsd_pkg::REG_RETRY_LIMIT:  cfg_in.retry_limit = pwdata[rsd_pkg::COUNT_W-1:0];
            rsd_pkg::REG_BACKOFF_BASE: cfg_in.backoff_base_ms = pwdata[rsd_pkg::MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rsd_pkg::REG_SPACING:
            prdata = {{(rsd_pkg::CSR_DATA_W-rsd_pkg::MS_W){1'b0}}, cfg_ff.spacing_ms};
         rsd_pkg::REG_RETRY_LIMIT:
            prdata = {{(rsd_pkg::CSR_DATA_W-rsd_pkg::COUNT_W){1'b0}}, cfg_ff.retry_limit};
         rsd_pkg::REG_BACKOFF_BASE:
            prdata = {{(rsd_pkg::CSR_DATA_W-rsd_pkg::MS_W){1'b0}}, cfg_ff.backoff_base_ms};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spacing_ms      <= rsd_pkg::SPACING_RST;
         cfg_ff.retry_limit     <= rsd_pkg::RETRY_LIMIT_RST;
         cfg_ff.backoff_base_ms <= rsd_pkg::BACKOFF_BASE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### design/rsd_core.sv
// Request state: spacing counter, backoff countdown, attempt count and decision logic.
`default_nettype none

module rsd_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,     // consume the held word this cycle
   input  wire rsd_pkg::req_type req,
   input  wire rsd_pkg::cfg_type cfg,
   output rsd_pkg::rsp_type      rsp
);

   localparam logic [rsd_pkg::PHASE_W-1:0] PH_IDLE    = 2'd0;
   localparam logic [rsd_pkg::PHASE_W-1:0] PH_WAIT    = 2'd1;
   localparam logic [rsd_pkg::PHASE_W-1:0] PH_ATTEMPT = 2'd2;

   logic [rsd_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [rsd_pkg::MS_W-1:0]    since_ff, since_in;
   logic [rsd_pkg::WAIT_W-1:0]  wait_ff, wait_in;
   logic [rsd_pkg::COUNT_W-1:0] count_ff, count_in;

   logic [rsd_pkg::WAIT_W-1:0]  wait_dec;
   logic [rsd_pkg::WAIT_W-1:0]  backoff;
   logic [rsd_pkg::MS_W-1:0]    gap;
   logic [rsd_pkg::COUNT_W-1:0] count_inc;
   logic                        retry_ok;

   assign wait_dec  = (wait_ff != '0) ? wait_ff - 1'b1 : wait_ff;
   assign backoff   = {{(rsd_pkg::WAIT_W-rsd_pkg::MS_W){1'b0}}, cfg.backoff_base_ms}
                      << count_ff;
   assign gap       = cfg.spacing_ms - since_ff;
   assign count_inc = count_ff + 1'b1;
   assign retry_ok  = (req.attempt_code != '0)
                   && (req.http_status == rsd_pkg::RATE_LIMITED_STATUS)
                   && (count_ff < cfg.retry_limit);

   always_comb begin
      phase_in = phase_ff;
      since_in = since_ff;
      wait_in  = wait_ff;
      count_in = count_ff;
      rsp      = '0;
      rsp.event_res = rsd_pkg::EV_NONE;

      case (req.command)
         rsd_pkg::CMD_TICK: begin
            if (since_ff != rsd_pkg::SINCE_SATURATED) begin
               since_in = since_ff + 1'b1;
            end
            if (phase_ff == PH_WAIT) begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  phase_in          = PH_ATTEMPT;
                  since_in          = '0;
                  rsp.event_res     = rsd_pkg::EV_START;
                  rsp.attempt_index = count_ff;
               end
            end
         end
         rsd_pkg::CMD_REQUEST: begin
            if (phase_ff != PH_IDLE) begin
               rsp.event_res = rsd_pkg::EV_BUSY;
            end else begin
               count_in = '0;
               if (since_ff >= cfg.spacing_ms) begin
                  phase_in      = PH_ATTEMPT;
                  since_in      = '0;
                  wait_in       = '0;
                  rsp.event_res = rsd_pkg::EV_START;
               end else begin
                  phase_in = PH_WAIT;
                  wait_in  = {{(rsd_pkg::WAIT_W-rsd_pkg::MS_W){1'b0}}, gap};
               end
            end
         end
         rsd_pkg::CMD_RESULT: begin
            if (phase_ff == PH_ATTEMPT) begin
               if (retry_ok) begin
                  count_in = count_inc;
                  wait_in  = backoff;
                  if (backoff == '0) begin
                     since_in          = '0;
                     rsp.event_res     = rsd_pkg::EV_START;
                     rsp.attempt_index = count_inc;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end else begin
                  phase_in          = PH_IDLE;
                  wait_in           = '0;
                  rsp.event_res     = rsd_pkg::EV_DONE;
                  rsp.final_code    = req.attempt_code;
                  rsp.final_status  = req.http_status;
                  rsp.attempt_index = count_ff;
               end
            end
         end
         default: ;  // unused command: no effect
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         since_ff <= rsd_pkg::SINCE_SATURATED;
         wait_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         since_ff <= since_in;
         wait_ff  <= wait_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### design/request_spacing_backoff_retry.sv
// Top level of the request spacing gate with rate-limit backoff and retry.
//
// Use: each request-channel word is a command: a 1 ms tick, a new request, or
// the result of an attempt (code and HTTP status). Each word yields exactly one
// response word: none, start an attempt now, request finished (with the last
// code, status and attempt number) or busy. New requests are held off until
// spacing_ms ticks have passed since the last attempt start; a 429 failure
// retries after backoff_base_ms << n ticks while n < retry_limit.
// Path: a taken request word goes into the input register, then into the result
// register (one input register, one result register). Throughput: one word per
// cycle while the receiver takes responses, set by the single decision stage.
// Stall: while the response is held by the receiver, one more request word is
// still taken into the input register; then req.ready drops until the
// response is taken. Nothing is dropped or repeated.
// Reset (synchronous, active high): registers go to 400 / 6 / 1000, the gate
// goes idle with the spacing counter saturated, so a first request starts at once.
// Configuration: APB-style, registers at byte addresses 0, 4, 8; write only
// while no word is in flight.
`default_nettype none

module request_spacing_backoff_retry (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rsd_req_if.sink                               req,
   rsd_rsp_if.source                             rsp,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [rsd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [rsd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [rsd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);

   rsd_pkg::cfg_type cfg;
   rsd_pkg::req_type in_word_ff, in_word_in;
   rsd_pkg::rsp_type out_word_ff, step_rsp;
   logic             in_valid_ff, in_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic             advance;
   logic             req_take;

   rsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Move the held word into the result register whenever that register is
   // empty or being drained this cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_take = req.valid && req.ready;

   rsd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_word_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   // Input register: load on accept, hold otherwise.
   always_comb begin
      in_word_in.command      = req.command;
      in_word_in.attempt_code = req.attempt_code;
      in_word_in.http_status  = req.http_status;
      in_valid_in = req_take || (in_valid_ff && !advance);
   end

   // Result register stays valid until taken, unless refilled.
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= in_word_in;
      end
      if (advance) begin
         out_word_ff <= step_rsp;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.event_res     = out_word_ff.event_res;
   assign rsp.final_code    = out_word_ff.final_code;
   assign rsp.final_status  = out_word_ff.final_status;
   assign rsp.attempt_index = out_word_ff.attempt_index;

endmodule

`default_nettype wire

### design/rsd_checker.sv
// Port-level checks of the request spacing gate, bound to the top level.
`default_nettype none
`include "request_spacing_backoff_retry_defines.svh"

module rsd_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_ready,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic [rsd_pkg::EVENT_W-1:0]         rsp_event_res,
   input  wire logic signed [rsd_pkg::CODE_W-1:0]   rsp_final_code,
   input  wire logic [rsd_pkg::STATUS_W-1:0]        rsp_final_status,
   input  wire logic [rsd_pkg::COUNT_W-1:0]         rsp_attempt_index
);

   // Reset empties both stages and opens the request side.
   `RSD_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_valid && req_ready, "not empty after reset")

   // A stalled response holds its word.
   `RSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_res) && $stable(rsp_final_code) && $stable(rsp_final_status) && $stable(rsp_attempt_index), "stalled response changed")

   // Code and status are carried only on a finish.
   `RSD_ASSERT_NOW(a_final_only_done, clock, reset, rsp_valid && (rsp_event_res != rsd_pkg::EV_DONE), (rsp_final_code == '0) && (rsp_final_status == '0), "final fields set off finish")

   // With the result side empty, the request side never stalls.
   `RSD_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "request stalled with empty output")

endmodule

bind request_spacing_backoff_retry rsd_checker u_rsd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_event_res     (rsp.event_res),
   .rsp_final_code    (rsp.final_code),
   .rsp_final_status  (rsp.final_status),
   .rsp_attempt_index (rsp.attempt_index)
);

`default_nettype wire

### sim/request_spacing_backoff_retry_tb.sv
// Self-checking testbench of the request spacing and backoff retry gate.
`timescale 1ns / 100ps

module request_spacing_backoff_retry_tb;

   // Command value the block has no use for: it must be dropped without a tick.
   localparam logic [rsd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 340;

   typedef enum logic [1:0] {
      GATE_IDLE,
      GATE_WAIT,
      GATE_ATTEMPT
   } gate_phase_type;

   logic clock = 1'b0;
   logic reset;

   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [rsd_pkg::CSR_ADDR_W-1:0] paddr;
   logic [rsd_pkg::CSR_DATA_W-1:0] pwdata;
   logic [rsd_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   rsd_req_if req_ch ();
   rsd_rsp_if rsp_ch ();

   request_spacing_backoff_retry uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   // Shadow copy of the gate: registers and state, advanced once per accepted word.
   rsd_pkg::cfg_type                gate_cfg;
   gate_phase_type                  gate_phase;
   logic [rsd_pkg::MS_W-1:0]        since_start_ms;
   logic [31:0]                     wait_left_ms;
   logic [rsd_pkg::COUNT_W-1:0]     attempt_no;

   rsd_pkg::rsp_type expected_rsp[$];
   int      mismatches = 0;
   // High: neither side idles, for the long stretches with a steady flow.
   bit      steady = 1'b0;

   // Mark the start of an attempt and build the start event for it.
   function automatic rsd_pkg::rsp_type launch_attempt();
      rsd_pkg::rsp_type r;
      r = '0;
      gate_phase = GATE_ATTEMPT;
      since_start_ms = '0;
      wait_left_ms = '0;
      r.event_res = rsd_pkg::EV_START;
      r.attempt_index = attempt_no;
      return r;
   endfunction

   // Advance the shadow gate by one word and return the event it must produce.
   function automatic rsd_pkg::rsp_type advance_gate(
         input logic [rsd_pkg::CMD_W-1:0] cmd,
         input logic signed [rsd_pkg::CODE_W-1:0] code,
         input logic [rsd_pkg::STATUS_W-1:0] status);
      rsd_pkg::rsp_type r;
      r = '0;
      case (cmd)
         rsd_pkg::CMD_TICK: begin
            if (since_start_ms != rsd_pkg::SINCE_SATURATED)
               since_start_ms = since_start_ms + 1'b1;
            if (gate_phase == GATE_WAIT) begin
               if (wait_left_ms != 0) wait_left_ms = wait_left_ms - 1;
               if (wait_left_ms == 0) r = launch_attempt();
            end
         end
         rsd_pkg::CMD_REQUEST: begin
            if (gate_phase != GATE_IDLE) begin
               r.event_res = rsd_pkg::EV_BUSY;
            end else begin
               attempt_no = '0;
               if (since_start_ms >= gate_cfg.spacing_ms) begin
                  r = launch_attempt();
               end else begin
                  wait_left_ms = 32'(gate_cfg.spacing_ms) - 32'(since_start_ms);
                  gate_phase = GATE_WAIT;
               end
            end
         end
         rsd_pkg::CMD_RESULT: begin
            if (gate_phase == GATE_ATTEMPT) begin
               // Only a real failure flagged as rate limited earns a retry.
               if (code != 0 && status == rsd_pkg::RATE_LIMITED_STATUS &&
                   attempt_no < gate_cfg.retry_limit) begin
                  wait_left_ms = 32'(gate_cfg.backoff_base_ms) << attempt_no;
                  attempt_no = attempt_no + 1'b1;
                  if (wait_left_ms == 0) r = launch_attempt();
                  else gate_phase = GATE_WAIT;
               end else begin
                  gate_phase = GATE_IDLE;
                  wait_left_ms = '0;
                  r.event_res = rsd_pkg::EV_DONE;
                  r.final_code = code;
                  r.final_status = status;
                  r.attempt_index = attempt_no;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Zero-extended readback value of one register, from the shadow copy.
   function automatic logic [rsd_pkg::CSR_DATA_W-1:0] register_value(input logic [1:0] idx);
      case (idx)
         rsd_pkg::REG_SPACING:     return rsd_pkg::CSR_DATA_W'(gate_cfg.spacing_ms);
         rsd_pkg::REG_RETRY_LIMIT: return rsd_pkg::CSR_DATA_W'(gate_cfg.retry_limit);
         default:                  return rsd_pkg::CSR_DATA_W'(gate_cfg.backoff_base_ms);
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   // Drive one word; predict its event at the edge where it is taken.
   task automatic send_word(input logic [rsd_pkg::CMD_W-1:0] cmd,
                            input logic signed [rsd_pkg::CODE_W-1:0] code,
                            input logic [rsd_pkg::STATUS_W-1:0] status);
      while (!steady && $urandom_range(99) < 15) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.attempt_code <= code;
      req_ch.http_status  <= status;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsp.push_back(advance_gate(cmd, code, status));
   endtask

   // Hold the sender until every pending event is back, then let the pipe empty.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, access cycle, done at the edge with pready.
   task automatic csr_cycle(input logic wr, input logic [1:0] idx,
                            input logic [rsd_pkg::CSR_DATA_W-1:0] wdata,
                            output logic [rsd_pkg::CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic verify_register(input logic [1:0] idx);
      logic [rsd_pkg::CSR_DATA_W-1:0] got;
      csr_cycle(1'b0, idx, '0, got);
      if (got !== register_value(idx))
         flag_mismatch($sformatf("register %0d readback: expected %0d, got %0d",
                                 idx, register_value(idx), got));
   endtask

   // Write a register with junk above its width, mirror it masked, read it back.
   task automatic program_register(input logic [1:0] idx, input int unsigned value);
      logic [rsd_pkg::CSR_DATA_W-1:0] wdata;
      logic [rsd_pkg::CSR_DATA_W-1:0] unused;
      settle();
      wdata = {$urandom} & 32'hFFF0_0000 | value;
      csr_cycle(1'b1, idx, wdata, unused);
      case (idx)
         rsd_pkg::REG_SPACING:     gate_cfg.spacing_ms      = wdata[rsd_pkg::MS_W-1:0];
         rsd_pkg::REG_RETRY_LIMIT: gate_cfg.retry_limit     = wdata[rsd_pkg::COUNT_W-1:0];
         default:                  gate_cfg.backoff_base_ms = wdata[rsd_pkg::MS_W-1:0];
      endcase
      verify_register(idx);
   endtask

   task automatic program_all(input int unsigned spacing, input int unsigned retries,
                              input int unsigned base_ms);
      program_register(rsd_pkg::REG_SPACING, spacing);
      program_register(rsd_pkg::REG_RETRY_LIMIT, retries);
      program_register(rsd_pkg::REG_BACKOFF_BASE, base_ms);
   endtask

   // Feed ticks until a pending attempt starts.
   task automatic tick_until_started();
      while (gate_phase == GATE_WAIT) send_word(rsd_pkg::CMD_TICK, '0, '0);
   endtask

   // Reset values, the saturated spacing counter against the widest interval,
   // busy and ignored words.
   task automatic test_after_reset();
      verify_register(rsd_pkg::REG_SPACING);
      verify_register(rsd_pkg::REG_RETRY_LIMIT);
      verify_register(rsd_pkg::REG_BACKOFF_BASE);
      program_register(rsd_pkg::REG_SPACING, 32'h0000_FFFF);
      send_word(rsd_pkg::CMD_REQUEST, '0, '0);
      send_word(rsd_pkg::CMD_REQUEST, '0, '0);
      // code zero wins over a rate-limited status
      send_word(rsd_pkg::CMD_RESULT, 8'sd0, rsd_pkg::RATE_LIMITED_STATUS);
      send_word(rsd_pkg::CMD_RESULT, -8'sd1, rsd_pkg::RATE_LIMITED_STATUS);
      send_word(CMD_UNUSED, 8'sd127, 10'h3FF);
      send_word(rsd_pkg::CMD_TICK, '0, '0);
      settle();
   endtask

   // Spacing wait, busy while waiting, doubling backoff and the retry limit.
   task automatic test_spacing_and_backoff();
      program_all(3, 2, 1);
      send_word(rsd_pkg::CMD_REQUEST, '0, '0);
      send_word(rsd_pkg::CMD_TICK, '0, '0);
      send_word(rsd_pkg::CMD_REQUEST, '0, '0);
      send_word(rsd_pkg::CMD_RESULT, -8'sd5, rsd_pkg::RATE_LIMITED_STATUS);
      tick_until_started();
      send_word(rsd_pkg::CMD_RESULT, -8'sd1, rsd_pkg::RATE_LIMITED_STATUS);
      tick_until_started();
      send_word(rsd_pkg::CMD_RESULT, 8'sd127, rsd_pkg::RATE_LIMITED_STATUS);
      tick_until_started();
      send_word(rsd_pkg::CMD_RESULT, -8'sd128, rsd_pkg::RATE_LIMITED_STATUS);
      // plain failure ends the request at once, then a success with status 0
      send_word(rsd_pkg::CMD_REQUEST, '0, '0);
      tick_until_started();
      send_word(rsd_pkg::CMD_RESULT, 8'sd5, 10'h3FF);
      send_word(rsd_pkg::CMD_REQUEST, '0, '0);
      tick_until_started();
      send_word(rsd_pkg::CMD_RESULT, 8'sd0, 10'd0);
      settle();
   endtask

   // Zero interval and zero backoff: every start happens in the same step,
   // up to the highest attempt number; then a lowered limit ends at once.
   task automatic test_zero_waits();
      program_all(0, 15, 0);
      send_word(rsd_pkg::CMD_REQUEST, '0, '0);
      repeat (16)
         send_word(rsd_pkg::CMD_RESULT, rsd_pkg::CODE_W'($urandom_range(1, 255)),
                   rsd_pkg::RATE_LIMITED_STATUS);
      program_register(rsd_pkg::REG_RETRY_LIMIT, 0);
      send_word(rsd_pkg::CMD_REQUEST, '0, '0);
      send_word(rsd_pkg::CMD_RESULT, 8'sd1, rsd_pkg::RATE_LIMITED_STATUS);
      settle();
   endtask

   // Doubling backoff counted down in a steady tick stream, up to the limit.
   task automatic test_long_backoff();
      program_all(0, 3, 8);
      steady = 1'b1;
      send_word(rsd_pkg::CMD_REQUEST, '0, '0);
      repeat (3) begin
         send_word(rsd_pkg::CMD_RESULT, -8'sd1, rsd_pkg::RATE_LIMITED_STATUS);
         tick_until_started();
      end
      send_word(rsd_pkg::CMD_RESULT, 8'sd1, rsd_pkg::RATE_LIMITED_STATUS);
      steady = 1'b0;
      settle();
   endtask

   // Mostly well-formed request flows with random content, some noise,
   // new settings every few dozen words and an occasional full drain.
   task automatic test_random_traffic();
      int counted;
      int burst_left;
      int roll;
      logic [rsd_pkg::CMD_W-1:0]         cmd;
      logic signed [rsd_pkg::CODE_W-1:0] code;
      logic [rsd_pkg::STATUS_W-1:0]      status;
      counted = 0;
      burst_left = 0;
      steady = 1'b1;
      while (counted < RANDOM_WORDS) begin
         if (counted >= 150) steady = 1'b0;
         if (burst_left == 0) begin
            program_all(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12),
                        ($urandom_range(7) == 0) ? 15 : $urandom_range(0, 6),
                        ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 5));
            burst_left = $urandom_range(40, 80);
         end else if ($urandom_range(99) < 2) begin
            settle();
         end
         cmd    = rsd_pkg::CMD_TICK;
         code   = rsd_pkg::CODE_W'($urandom);
         status = rsd_pkg::STATUS_W'($urandom_range(0, 1023));
         roll   = $urandom_range(99);
         if (roll < 8) begin
            cmd = rsd_pkg::CMD_W'($urandom_range(0, 3));
         end else begin
            case (gate_phase)
               GATE_IDLE: cmd = (roll < 55) ? rsd_pkg::CMD_REQUEST : rsd_pkg::CMD_TICK;
               GATE_WAIT: cmd = (roll < 92) ? rsd_pkg::CMD_TICK : rsd_pkg::CMD_REQUEST;
               default:   cmd = (roll < 80) ? rsd_pkg::CMD_RESULT : rsd_pkg::CMD_TICK;
            endcase
         end
         if (cmd == rsd_pkg::CMD_RESULT) begin
            if ($urandom_range(3) == 0) code = '0;
            if ($urandom_range(1) == 1) status = rsd_pkg::RATE_LIMITED_STATUS;
         end
         // words the gate just drops do not advance the count
         if (!(cmd == CMD_UNUSED ||
               (cmd == rsd_pkg::CMD_RESULT && gate_phase != GATE_ATTEMPT)))
            counted++;
         burst_left--;
         send_word(cmd, code, status);
      end
      settle();
   endtask

   // Receiver: stall at random unless the flow is meant to be steady.
   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 15);
   end

   // Compare each taken event word with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      rsd_pkg::rsp_type got;
      rsd_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.event_res     = rsp_ch.event_res;
         got.final_code    = rsp_ch.final_code;
         got.final_status  = rsp_ch.final_status;
         got.attempt_index = rsp_ch.attempt_index;
         if (expected_rsp.size() == 0) begin
            flag_mismatch($sformatf("event word %0d/%0d/%0d/%0d with nothing pending",
                                    got.event_res, got.final_code, got.final_status,
                                    got.attempt_index));
         end else begin
            want = expected_rsp.pop_front();
            if (got !== want)
               flag_mismatch($sformatf(
                  "want ev %0d code %0d st %0d idx %0d, got ev %0d code %0d st %0d idx %0d",
                  want.event_res, want.final_code, want.final_status, want.attempt_index,
                  got.event_res, got.final_code, got.final_status, got.attempt_index));
         end
      end
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.command      = rsd_pkg::CMD_TICK;
      req_ch.attempt_code = '0;
      req_ch.http_status  = '0;
      rsp_ch.ready        = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;

      // shadow gate starts where the block comes out of reset
      gate_cfg.spacing_ms      = rsd_pkg::SPACING_RST;
      gate_cfg.retry_limit     = rsd_pkg::RETRY_LIMIT_RST;
      gate_cfg.backoff_base_ms = rsd_pkg::BACKOFF_BASE_RST;
      gate_phase     = GATE_IDLE;
      since_start_ms = rsd_pkg::SINCE_SATURATED;
      wait_left_ms   = '0;
      attempt_no     = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_spacing_and_backoff();
      test_zero_waits();
      test_long_backoff();
      test_random_traffic();

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/rsd_pkg.sv
design/rsd_if.sv
design/rsd_csr.sv
design/rsd_core.sv
design/request_spacing_backoff_retry.sv
design/rsd_checker.sv
sim/request_spacing_backoff_retry_tb.sv
